FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; clk_i and rst_ni must be in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/sbeq_pkg.sv
// ----------------------------------------------------------------------------
// sbeq_pkg
// Types, codes and fixed widths shared by the equalizer modules.
// ----------------------------------------------------------------------------
package sbeq_pkg;

  localparam int SLOT_COUNT = 5;
  localparam int SLOT_W     = 3;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_IN_W  = 32;
  localparam int IDX_W      = 5;
  localparam int CMD_W      = 2;
  localparam int ACC_W      = 64;
  localparam int HIST_W     = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 5;
  localparam int OP_STEPS   = 9;
  localparam int PIPE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PROCESS = 2'd0,
    CMD_COEF    = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EQ_ENABLE   = 1'b0,
    REG_BAND_ENABLE = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_B0, OP_B1, OP_B2, OP_A1L, OP_A1H, OP_A1S, OP_A2L, OP_A2H, OP_A2S
  } op_e;

  typedef struct packed {
    logic load_in;
    logic coef_wr;
    logic clear;
    logic start_job;
    op_e  op;
    logic finish_job;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  // op sequence of one band/channel job
  function automatic op_e step_op(logic [3:0] step);
    op_e r;
    unique case (step)
      4'd0:    r = OP_B0;
      4'd1:    r = OP_B1;
      4'd2:    r = OP_B2;
      4'd3:    r = OP_A1L;
      4'd4:    r = OP_A1H;
      4'd5:    r = OP_A1S;
      4'd6:    r = OP_A2L;
      4'd7:    r = OP_A2H;
      4'd8:    r = OP_A2S;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  // coefficient slot read by an op
  function automatic logic [SLOT_W-1:0] op_slot(op_e op);
    logic [SLOT_W-1:0] r;
    unique case (op) inside
      OP_B1:          r = 3'd1;
      OP_B2:          r = 3'd2;
      OP_A1L, OP_A1H: r = 3'd3;
      OP_A2L, OP_A2H: r = 3'd4;
      default:        r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/sbeq_in_if.sv
// ----------------------------------------------------------------------------
// sbeq_in_if
// Input channel: command items with frame, coefficient and clear payload.
// ----------------------------------------------------------------------------
interface sbeq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [sbeq_pkg::CMD_W-1:0]    cmd;
  logic signed [sbeq_pkg::SAMPLE_W-1:0] left_in;
  logic signed [sbeq_pkg::SAMPLE_W-1:0] right_in;
  logic        [sbeq_pkg::IDX_W-1:0]    coef_index;
  logic signed [sbeq_pkg::COEF_IN_W-1:0] coef_value;
  logic                                 end_of_block;

  modport source (output valid, cmd, left_in, right_in, coef_index, coef_value,
                  end_of_block, input ready);
  modport sink   (input valid, cmd, left_in, right_in, coef_index, coef_value,
                  end_of_block, output ready);
endinterface

FILE: rtl/sbeq_out_if.sv
// ----------------------------------------------------------------------------
// sbeq_out_if
// Output channel: filtered stereo frames.
// ----------------------------------------------------------------------------
interface sbeq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sbeq_pkg::SAMPLE_W-1:0] left_out;
  logic signed [sbeq_pkg::SAMPLE_W-1:0] right_out;
  logic                                 end_of_block_out;

  modport source (output valid, left_out, right_out, end_of_block_out, input ready);
  modport sink   (input valid, left_out, right_out, end_of_block_out, output ready);
endinterface

FILE: rtl/sbeq_datapath.sv
// ----------------------------------------------------------------------------
// sbeq_datapath
// Coefficient and history memories, shared MAC pipeline, output register.
// ----------------------------------------------------------------------------
module sbeq_datapath #(
  parameter int BAND_COUNT    = 5,
  parameter int CHANNEL_COUNT = 2,
  parameter int COEF_WIDTH    = 32,
  parameter int BW            = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sbeq_pkg::dp_cmd_t                    cmd_i,
  input  logic [BW-1:0]                        band_i,
  input  logic                                 ch_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0] right_in_i,
  input  logic [sbeq_pkg::IDX_W-1:0]           coef_index_i,
  input  logic signed [sbeq_pkg::COEF_IN_W-1:0] coef_value_i,
  input  logic                                 end_of_block_i,
  output sbeq_pkg::dp_stat_t                   stat_o,
  sbeq_out_if.source                           out_o
);
  import sbeq_pkg::*;

  localparam int EFF_W = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
  localparam int TD    = BAND_COUNT * SLOT_COUNT;
  localparam int AW    = $clog2(TD);
  localparam int HD    = BAND_COUNT * CHANNEL_COUNT;
  localparam int HW    = (HD > 1) ? $clog2(HD) : 1;

  function automatic logic signed [ACC_W-1:0] sat64(logic signed [ACC_W:0] s);
    logic signed [ACC_W-1:0] r;
    if (s[ACC_W] != s[ACC_W-1]) r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                             : {1'b0, {(ACC_W-1){1'b1}}};
    else r = s[ACC_W-1:0];
    return r;
  endfunction

  logic [EFF_W-1:0]                 coef_mem [TD];
  logic signed [SAMPLE_W-1:0]       in1_mem  [HD];
  logic signed [SAMPLE_W-1:0]       in2_mem  [HD];
  logic signed [HIST_W-1:0]         out1_mem [HD];
  logic signed [HIST_W-1:0]         out2_mem [HD];
  logic [HD-1:0]                    hvalid_q;

  logic [EFF_W-1:0]                 coef_q;
  logic signed [SAMPLE_W-1:0]       x1r_q, x2r_q;
  logic signed [HIST_W-1:0]         y1r_q, y2r_q;
  logic                             hv_q;
  logic signed [SAMPLE_W-1:0]       s_q [2];
  logic                             eob_q;
  op_e                              op1_q, op2_q;
  logic signed [ACC_W-1:0]          prod_q, low_q, term_q, acc_q;
  logic                             out_valid_q;
  logic signed [SAMPLE_W-1:0]       out_l_q, out_r_q;
  logic                             out_eob_q;

  logic [HW-1:0]                    hidx;
  logic [AW-1:0]                    rd_addr, wr_addr;
  logic                             wr_ok;
  logic signed [SAMPLE_W-1:0]       x0, x1, x2;
  logic signed [HIST_W-1:0]         y1, y2;
  logic signed [32:0]               coef_s, opb;
  logic signed [65:0]               prod_full;
  logic signed [52:0]               ysh;
  logic signed [HIST_W-1:0]         y_new;
  logic signed [36:0]               q;
  logic                             rnd;
  logic signed [SAMPLE_W-1:0]       o_new;

  assign hidx    = HW'(int'(band_i) * CHANNEL_COUNT + int'(ch_i));
  assign rd_addr = AW'(int'(band_i) * SLOT_COUNT + int'(op_slot(cmd_i.op)));
  assign wr_addr = AW'(coef_index_i);
  assign wr_ok   = int'(coef_index_i) < TD;

  // coefficient table
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr && wr_ok) coef_mem[wr_addr] <= coef_value_i[EFF_W-1:0];
    coef_q <= coef_mem[rd_addr];
  end

  // history memories; unwritten or cleared entries read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_job) begin
      x1r_q <= in1_mem[hidx];
      x2r_q <= in2_mem[hidx];
      y1r_q <= out1_mem[hidx];
      y2r_q <= out2_mem[hidx];
      hv_q  <= hvalid_q[hidx];
    end
    if (cmd_i.finish_job) begin
      in1_mem[hidx]  <= x0;
      in2_mem[hidx]  <= x1;
      out1_mem[hidx] <= y_new;
      out2_mem[hidx] <= y1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
    end else if (cmd_i.clear) begin
      hvalid_q <= '0;
    end else if (cmd_i.finish_job) begin
      hvalid_q[hidx] <= 1'b1;
    end
  end

  assign x0 = s_q[ch_i];
  assign x1 = hv_q ? x1r_q : '0;
  assign x2 = hv_q ? x2r_q : '0;
  assign y1 = hv_q ? y1r_q : '0;
  assign y2 = hv_q ? y2r_q : '0;

  // stage 1: multiply; history high half is signed, low half unsigned
  assign coef_s = {{(33-EFF_W){coef_q[EFF_W-1]}}, coef_q};

  always_comb begin
    case (op1_q)
      OP_B0:   opb = 33'(x0);
      OP_B1:   opb = 33'(x1);
      OP_B2:   opb = 33'(x2);
      OP_A1L:  opb = {17'b0, y1[15:0]};
      OP_A1H:  opb = 33'($signed(y1[47:16]));
      OP_A2L:  opb = {17'b0, y2[15:0]};
      OP_A2H:  opb = 33'($signed(y2[47:16]));
      default: opb = '0;
    endcase
  end

  assign prod_full = coef_s * opb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q <= OP_NONE;
      op2_q <= OP_NONE;
    end else begin
      op1_q <= cmd_i.op;
      op2_q <= op1_q;
    end
  end

  // stage 2: accumulate; feedback term = hi product + floor(lo product / 2^16)
  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[ACC_W-1:0];
    if (cmd_i.start_job) begin
      acc_q <= '0;
    end else begin
      case (op2_q) inside
        OP_B0, OP_B1, OP_B2: acc_q  <= sat64({prod_q[ACC_W-1], prod_q} +
                                             {acc_q[ACC_W-1], acc_q});
        OP_A1L, OP_A2L:      low_q  <= prod_q >>> 16;
        OP_A1H, OP_A2H:      term_q <= prod_q + low_q;
        OP_A1S, OP_A2S:      acc_q  <= sat64({acc_q[ACC_W-1], acc_q} -
                                             {term_q[ACC_W-1], term_q});
        default: ;
      endcase
    end
  end

  // end of job: history value and sample passed on
  assign ysh = $signed(acc_q[63:11]);
  assign y_new = (&ysh[52:47] || !(|ysh[52:47])) ? ysh[47:0]
               : (ysh[52] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}});
  assign rnd   = acc_q[63] & (|acc_q[26:0]);
  assign q     = $signed(acc_q[63:27]) + $signed({36'b0, rnd});
  assign o_new = (&q[36:15] || !(|q[36:15])) ? q[15:0]
               : (q[36] ? 16'sh8000 : 16'sh7fff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      s_q[0] <= left_in_i;
      s_q[1] <= right_in_i;
      eob_q  <= end_of_block_i;
    end else if (cmd_i.finish_job) begin
      s_q[ch_i] <= o_new;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_l_q   <= s_q[0];
      out_r_q   <= s_q[1];
      out_eob_q <= eob_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.left_out         = out_l_q;
  assign out_o.right_out        = out_r_q;
  assign out_o.end_of_block_out = out_eob_q;
  assign stat_o.out_busy        = out_valid_q && !out_o.ready;

endmodule

FILE: rtl/sbeq_ctrl.sv
// ----------------------------------------------------------------------------
// sbeq_ctrl
// Config registers and sequencer walking bands, channels and MAC ops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbeq_ctrl #(
  parameter int BAND_COUNT    = 5,
  parameter int CHANNEL_COUNT = 2,
  parameter int BW            = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sbeq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sbeq_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  input  logic [sbeq_pkg::CMD_W-1:0]        in_cmd_i,
  output logic                              in_ready_o,
  input  sbeq_pkg::dp_stat_t                stat_i,
  output sbeq_pkg::dp_cmd_t                 cmd_o,
  output logic [BW-1:0]                     band_o,
  output logic                              ch_o
);
  import sbeq_pkg::*;

  localparam int NCH = (CHANNEL_COUNT < 2) ? CHANNEL_COUNT : 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NEXT, ST_START, ST_ISSUE, ST_DRAIN, ST_FINISH, ST_DONE
  } state_e;

  state_e          state_q;
  logic [BW-1:0]   band_q;
  logic            ch_q;
  logic [3:0]      step_q;
  logic            eq_en_q;
  logic [CFG_W-1:0] band_en_q;

  logic            in_fire, active, band_en, band_last, ch_last;
  logic [CFG_W-1:0] band_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_en_q   <= 1'b0;
      band_en_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_EQ_ENABLE:   eq_en_q   <= cfg_data_i[0];
        REG_BAND_ENABLE: band_en_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign active     = eq_en_q && (|band_en_q);
  assign band_sh    = band_en_q >> band_q;
  assign band_en    = band_sh[0];
  assign band_last  = (band_q == BW'(BAND_COUNT - 1));
  assign ch_last    = (ch_q == 1'(NCH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      band_q  <= '0;
      ch_q    <= 1'b0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && in_cmd_i == CMD_PROCESS) begin
            band_q  <= '0;
            ch_q    <= 1'b0;
            state_q <= active ? ST_NEXT : ST_DONE;
          end
        end
        ST_NEXT: begin
          if (band_en) state_q <= ST_START;
          else if (band_last) state_q <= ST_DONE;
          else band_q <= band_q + 1'b1;
        end
        ST_START: begin
          step_q  <= '0;
          state_q <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (step_q == 4'(OP_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= ST_DRAIN;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (step_q == 4'(PIPE_DEPTH - 1)) begin
            step_q  <= '0;
            state_q <= ST_FINISH;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_FINISH: begin
          if (!ch_last) begin
            ch_q    <= ch_q + 1'b1;
            state_q <= ST_START;
          end else begin
            ch_q <= 1'b0;
            if (band_last) state_q <= ST_DONE;
            else begin
              band_q  <= band_q + 1'b1;
              state_q <= ST_NEXT;
            end
          end
        end
        ST_DONE: begin
          if (!stat_i.out_busy) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.op         = (state_q == ST_ISSUE) ? step_op(step_q) : OP_NONE;
    cmd_o.load_in    = in_fire && (in_cmd_i == CMD_PROCESS);
    cmd_o.coef_wr    = in_fire && (in_cmd_i == CMD_COEF);
    cmd_o.clear      = in_fire && (in_cmd_i == CMD_CLEAR);
    cmd_o.start_job  = (state_q == ST_START);
    cmd_o.finish_job = (state_q == ST_FINISH);
    cmd_o.load_out   = (state_q == ST_DONE) && !stat_i.out_busy;
  end

  assign band_o = band_q;
  assign ch_o   = ch_q;

  `ASSERT_IMPL(a_cmd_excl, 1'b1, $onehot0({cmd_o.start_job, cmd_o.finish_job, cmd_o.load_out, cmd_o.op != OP_NONE}))
  `ASSERT_NEXT(a_frame_busy, in_fire && in_cmd_i == CMD_PROCESS, !in_ready_o)
  `ASSERT_NEXT(a_start_issue, state_q == ST_START, state_q == ST_ISSUE && step_q == 4'd0)

endmodule

FILE: rtl/stereo_biquad_eq_cascade.sv
// ----------------------------------------------------------------------------
// stereo_biquad_eq_cascade
// Stereo cascade of direct-form-I biquads with one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - in_i carries items: cmd process (stereo frame), coefficient write, or
//    history clear. out_o carries one frame per process item (filtered or bypassed).
//  - cfg port writes eq_enable (index 0) and band_enable (index 1); write only
//    while the block is idle.
//  - Coefficient writes and clears take effect on their transfer.
//  - A frame that bypasses (eq off or no band on) goes from the input register
//    to the output register from the done state, which then returns to idle for the next item.
//  - A filtered frame reaches the output register after one job per channel for
//    every enabled band: each band/channel job runs nine ops through the single
//    33x33 multiply-accumulate pipe, plus history read, pipeline drain and
//    history write-back.
//  - in_i.ready is high only while the sequencer is idle; one item at a time.
//  - The output register holds a finished frame while out_o is stalled; the
//    next item is still taken, but its result waits until the register frees.
//  - Reset clears config, output valid and all history valid bits (history
//    reads as zero). Coefficients are undefined until written.
// ----------------------------------------------------------------------------
module stereo_biquad_eq_cascade #(
  parameter int BAND_COUNT    = 5,
  parameter int CHANNEL_COUNT = 2,
  parameter int COEF_WIDTH    = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sbeq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sbeq_pkg::CFG_W-1:0]     cfg_data_i,
  sbeq_in_if.sink                        in_i,
  sbeq_out_if.source                     out_o
);
  import sbeq_pkg::*;

  localparam int BW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

  dp_cmd_t        dp_cmd;
  dp_stat_t       dp_stat;
  logic [BW-1:0]  band;
  logic           ch;
  logic           ready;

  assign in_i.ready = ready;

  // sequencer: config registers, band/channel walk, op issue
  sbeq_ctrl #(
    .BAND_COUNT   (BAND_COUNT),
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .BW           (BW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_i.valid),
    .in_cmd_i  (in_i.cmd),
    .in_ready_o(ready),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .band_o    (band),
    .ch_o      (ch)
  );

  // memories, MAC pipe and output register
  sbeq_datapath #(
    .BAND_COUNT   (BAND_COUNT),
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .COEF_WIDTH   (COEF_WIDTH),
    .BW           (BW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .band_i        (band),
    .ch_i          (ch),
    .left_in_i     (in_i.left_in),
    .right_in_i    (in_i.right_in),
    .coef_index_i  (in_i.coef_index),
    .coef_value_i  (in_i.coef_value),
    .end_of_block_i(in_i.end_of_block),
    .stat_o        (dp_stat),
    .out_o         (out_o)
  );

endmodule
